// File: hw/rtl/ansi_terminal_page_parser_defines.svh
// Assertion macros for the terminal page parser.
`ifndef ANSI_TERMINAL_PAGE_PARSER_DEFINES_SVH
`define ANSI_TERMINAL_PAGE_PARSER_DEFINES_SVH
`define ATP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ATP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/atp_pkg.sv
// Package: parser codes, sequencer states and constants.
package atp_pkg;
    typedef enum logic [1:0] {
        MODE_GROUND = 2'd0,
        MODE_LEAD   = 2'd1,
        MODE_ESC    = 2'd2,
        MODE_SEQ    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        FORM_NONE    = 3'd0,
        FORM_DIRECT  = 3'd1,
        FORM_BRACKET = 3'd2,
        FORM_FIRST   = 3'd3,
        FORM_SEMI    = 3'd4,
        FORM_SECOND  = 3'd5,
        FORM_OTHER   = 3'd6
    } form_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PUT1,
        ST_PUT2,
        ST_ERASE,
        ST_READ,
        ST_READW,
        ST_RESP
    } state_t;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] LEAD_LO  = 8'h81;
    localparam logic [7:0] LEAD_HI  = 8'hFE;
    localparam logic [7:0] TR1_LO   = 8'h40;
    localparam logic [7:0] TR1_HI   = 8'h7E;
    localparam logic [7:0] TR2_LO   = 8'hA1;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_M     = 8'h4D;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction
endpackage

// File: hw/rtl/ansi_terminal_page_parser.sv
// Top level: terminal byte parser with page store, cursor and cell readback.
// One item is taken at a time. A text or control byte is accepted in IDLE, then
// passes DECODE and RESP. A byte that follows a held Big5 lead passes DECODE and
// PUT1, because the lead cell is written first, and then either PUT2 for the trail
// cell or DECODE again for the byte itself. A cell read passes READ, READW and RESP,
// skipping READW when it is out of range. An erase walks one cell per cycle through
// the single page RAM port, up to SCREEN_ROWS*SCREEN_COLS cells for a full screen.
// After reset a clearing pass writes spaces to all STORE_ROWS*SCREEN_COLS cells,
// one per cycle, before the first item is taken.
`include "ansi_terminal_page_parser_defines.svh"
module ansi_terminal_page_parser #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 80,
    parameter int STORE_ROWS  = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_data_byte,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_char,
    output logic [4:0] m_cursor_row,
    output logic [6:0] m_cursor_col,
    output logic       m_escape_active
);
    localparam int DEPTH = STORE_ROWS * SCREEN_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(STORE_ROWS);
    localparam int CW = $clog2(SCREEN_COLS);
    localparam int RW = $clog2(SCREEN_ROWS);

    atp_pkg::state_t state_reg, state_next;
    atp_pkg::mode_t  mode_reg, mode_next;
    atp_pkg::form_t  form_reg, form_next;
    logic [TW-1:0] top_reg, top_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] n1_reg, n1_next;
    logic [7:0] n2_reg, n2_next;
    logic [7:0] byte_reg, byte_next;
    logic [4:0] rrow_reg, rrow_next;
    logic [6:0] rcol_reg, rcol_next;
    logic [7:0] cell_reg, cell_next;
    // erase walk: current row/col and last row/col (inclusive)
    logic [RW-1:0] er_reg, er_next, erl_reg, erl_next;
    logic [CW-1:0] ec_reg, ec_next, ecl_reg, ecl_next;
    logic [AW-1:0] clr_reg, clr_next;

    // shared address unit: (top + r) mod STORE_ROWS, times cols, plus c
    logic [RW-1:0] a_row;
    logic [CW-1:0] a_col;
    logic [TW:0]   a_sum;
    logic [TW-1:0] a_ring;
    logic [AW-1:0] a_addr;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    always_comb begin
        a_sum  = (TW+1)'(top_reg) + (TW+1)'(a_row);
        a_ring = (a_sum >= (TW+1)'(STORE_ROWS)) ? TW'(a_sum - (TW+1)'(STORE_ROWS))
                                                : TW'(a_sum);
        a_addr = AW'(a_ring * SCREEN_COLS) + AW'(a_col);
    end

    atp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_page (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [7:0] b;
    logic       is_dig, trail_ok;
    logic [7:0] dig;
    logic [11:0] acc1, acc2;
    logic [8:0]  nval;
    assign b = byte_reg;
    assign is_dig = (b >= atp_pkg::CH_0) && (b <= atp_pkg::CH_9);
    assign dig = b - atp_pkg::CH_0;
    assign trail_ok = (b >= atp_pkg::TR1_LO && b <= atp_pkg::TR1_HI) ||
                      (b >= atp_pkg::TR2_LO && b <= atp_pkg::LEAD_HI);
    assign acc1 = 12'(n1_reg) * 12'd10 + 12'(dig);
    assign acc2 = 12'(n2_reg) * 12'd10 + 12'(dig);
    assign nval = (form_reg == atp_pkg::FORM_BRACKET) ? 9'd0 :
                  (form_reg == atp_pkg::FORM_FIRST) ? {1'b0, n1_reg} : 9'd256;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atp_pkg::ST_CLEAR;
            mode_reg  <= atp_pkg::MODE_GROUND;
            form_reg  <= atp_pkg::FORM_NONE;
            top_reg   <= TW'(STORE_ROWS / 2);
            row_reg   <= '0;
            col_reg   <= '0;
            lead_reg  <= '0;
            n1_reg    <= '0;
            n2_reg    <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            form_reg  <= form_next;
            top_reg   <= top_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            lead_reg  <= lead_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            clr_reg   <= clr_next;
        end
        byte_reg <= byte_next;
        rrow_reg <= rrow_next;
        rcol_reg <= rcol_next;
        cell_reg <= cell_next;
        er_reg   <= er_next;
        erl_reg  <= erl_next;
        ec_reg   <= ec_next;
        ecl_reg  <= ecl_next;
    end

    // next-state and datapath
    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg;
        form_next = form_reg;
        top_next = top_reg;
        row_next = row_reg;
        col_next = col_reg;
        lead_next = lead_reg;
        n1_next = n1_reg;
        n2_next = n2_reg;
        byte_next = byte_reg;
        rrow_next = rrow_reg;
        rcol_next = rcol_reg;
        cell_next = cell_reg;
        er_next = er_reg;
        erl_next = erl_reg;
        ec_next = ec_reg;
        ecl_next = ecl_reg;
        clr_next = clr_reg;
        unique case (state_reg)
            atp_pkg::ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = atp_pkg::ST_IDLE;
                end
            end
            atp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data_byte;
                    rrow_next = s_read_row;
                    rcol_next = s_read_col;
                    cell_next = '0;
                    state_next = s_func ? atp_pkg::ST_READ : atp_pkg::ST_DECODE;
                end
            end
            atp_pkg::ST_READ: begin
                if (32'(rrow_reg) < SCREEN_ROWS && 32'(rcol_reg) < SCREEN_COLS) begin
                    state_next = atp_pkg::ST_READW;
                end else begin
                    state_next = atp_pkg::ST_RESP;
                end
            end
            atp_pkg::ST_READW: begin
                cell_next = ram_rdata;
                state_next = atp_pkg::ST_RESP;
            end
            atp_pkg::ST_PUT1: begin
                // lead byte written; then either the trail or re-decode as ground
                if (32'(col_reg) < SCREEN_COLS - 1) col_next = col_reg + 1'b1;
                if (trail_ok) begin
                    state_next = atp_pkg::ST_PUT2;
                end else begin
                    state_next = atp_pkg::ST_DECODE;
                end
            end
            atp_pkg::ST_PUT2: begin
                if (32'(col_reg) < SCREEN_COLS - 1) col_next = col_reg + 1'b1;
                state_next = atp_pkg::ST_RESP;
            end
            atp_pkg::ST_ERASE: begin
                if (er_reg == erl_reg && ec_reg == ecl_reg) begin
                    state_next = atp_pkg::ST_RESP;
                end else if (ec_reg == CW'(SCREEN_COLS - 1)) begin
                    ec_next = '0;
                    er_next = er_reg + 1'b1;
                end else begin
                    ec_next = ec_reg + 1'b1;
                end
            end
            atp_pkg::ST_RESP: begin
                if (m_ready) state_next = atp_pkg::ST_IDLE;
            end
            atp_pkg::ST_DECODE: begin
                state_next = atp_pkg::ST_RESP;
                unique case (mode_reg)
                    atp_pkg::MODE_LEAD: begin
                        mode_next = atp_pkg::MODE_GROUND;
                        state_next = atp_pkg::ST_PUT1;
                    end
                    atp_pkg::MODE_ESC: begin
                        if (b == atp_pkg::CH_8 || b == atp_pkg::CH_9) begin
                            mode_next = atp_pkg::MODE_GROUND;
                        end else if (atp_pkg::is_letter(b)) begin
                            mode_next = atp_pkg::MODE_GROUND;
                            form_next = atp_pkg::FORM_NONE;
                            if (b == atp_pkg::CH_M) begin
                                top_next = (top_reg == '0) ? TW'(STORE_ROWS - 1)
                                                           : top_reg - 1'b1;
                            end
                        end else begin
                            form_next = (b == atp_pkg::CH_LBR) ? atp_pkg::FORM_BRACKET
                                                               : atp_pkg::FORM_OTHER;
                            mode_next = atp_pkg::MODE_SEQ;
                        end
                    end
                    atp_pkg::MODE_SEQ: begin
                        if (atp_pkg::is_letter(b)) begin
                            mode_next = atp_pkg::MODE_GROUND;
                            form_next = atp_pkg::FORM_NONE;
                            if (b == atp_pkg::CH_H) begin
                                if (form_reg == atp_pkg::FORM_BRACKET) begin
                                    row_next = '0;
                                    col_next = '0;
                                end else if (form_reg == atp_pkg::FORM_SECOND) begin
                                    if (n1_reg == 8'd0) row_next = '0;
                                    else if (32'(n1_reg) > SCREEN_ROWS)
                                        row_next = RW'(SCREEN_ROWS - 1);
                                    else row_next = RW'(n1_reg - 8'd1);
                                    if (n2_reg == 8'd0) col_next = '0;
                                    else if (32'(n2_reg) > SCREEN_COLS)
                                        col_next = CW'(SCREEN_COLS - 1);
                                    else col_next = CW'(n2_reg - 8'd1);
                                end
                            end else if ((b == atp_pkg::CH_K || b == atp_pkg::CH_J)
                                         && nval <= 9'd2) begin
                                state_next = atp_pkg::ST_ERASE;
                                er_next = row_reg;
                                erl_next = row_reg;
                                ec_next = '0;
                                ecl_next = CW'(SCREEN_COLS - 1);
                                if (nval == 9'd0) begin
                                    ec_next = col_reg;
                                    if (b == atp_pkg::CH_J)
                                        erl_next = RW'(SCREEN_ROWS - 1);
                                end else if (nval == 9'd1) begin
                                    ecl_next = col_reg;
                                    if (b == atp_pkg::CH_J) er_next = '0;
                                end else if (b == atp_pkg::CH_J) begin
                                    er_next = '0;
                                    erl_next = RW'(SCREEN_ROWS - 1);
                                end
                            end
                        end else if (is_dig) begin
                            if (form_reg == atp_pkg::FORM_BRACKET) begin
                                n1_next = dig;
                                form_next = atp_pkg::FORM_FIRST;
                            end else if (form_reg == atp_pkg::FORM_FIRST) begin
                                n1_next = (acc1 > 12'd255) ? 8'd255 : acc1[7:0];
                            end else if (form_reg == atp_pkg::FORM_SEMI) begin
                                n2_next = dig;
                                form_next = atp_pkg::FORM_SECOND;
                            end else if (form_reg == atp_pkg::FORM_SECOND) begin
                                n2_next = (acc2 > 12'd255) ? 8'd255 : acc2[7:0];
                            end else begin
                                form_next = atp_pkg::FORM_OTHER;
                            end
                        end else if (b == atp_pkg::CH_SEMI &&
                                     form_reg == atp_pkg::FORM_FIRST) begin
                            form_next = atp_pkg::FORM_SEMI;
                        end else begin
                            form_next = atp_pkg::FORM_OTHER;
                        end
                    end
                    default: begin
                        if (b == atp_pkg::CH_ESC) begin
                            mode_next = atp_pkg::MODE_ESC;
                            n1_next = '0;
                            n2_next = '0;
                            form_next = atp_pkg::FORM_NONE;
                        end else if (b == atp_pkg::CH_CR) begin
                            col_next = '0;
                        end else if (b == atp_pkg::CH_LF) begin
                            if (32'(row_reg) >= SCREEN_ROWS - 1) begin
                                top_next = (32'(top_reg) == STORE_ROWS - 1) ? '0
                                                                    : top_reg + 1'b1;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else if (b == atp_pkg::CH_BS) begin
                            if (col_reg != '0) col_next = col_reg - 1'b1;
                        end else if (b == atp_pkg::CH_BEL || b == atp_pkg::CH_VT ||
                                     b == atp_pkg::CH_FF) begin
                            mode_next = mode_reg;
                        end else if (b >= atp_pkg::LEAD_LO && b <= atp_pkg::LEAD_HI) begin
                            lead_next = b;
                            mode_next = atp_pkg::MODE_LEAD;
                        end else begin
                            if (32'(col_reg) < SCREEN_COLS - 1) col_next = col_reg + 1'b1;
                        end
                    end
                endcase
            end
            default: state_next = atp_pkg::ST_IDLE;
        endcase
    end

    // RAM port control
    logic plain_put;
    assign plain_put = (mode_reg == atp_pkg::MODE_GROUND) &&
        !(b == atp_pkg::CH_ESC || b == atp_pkg::CH_CR || b == atp_pkg::CH_LF ||
          b == atp_pkg::CH_BS || b == atp_pkg::CH_BEL || b == atp_pkg::CH_VT ||
          b == atp_pkg::CH_FF || (b >= atp_pkg::LEAD_LO && b <= atp_pkg::LEAD_HI));
    always_comb begin
        a_row = row_reg;
        a_col = col_reg;
        ram_we = 1'b0;
        ram_wdata = b;
        ram_addr = a_addr;
        unique case (state_reg)
            atp_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                ram_wdata = atp_pkg::CH_SPACE;
                ram_addr = clr_reg;
            end
            atp_pkg::ST_DECODE: ram_we = plain_put;
            atp_pkg::ST_PUT1: begin
                ram_we = 1'b1;
                ram_wdata = lead_reg;
            end
            atp_pkg::ST_PUT2: ram_we = 1'b1;
            atp_pkg::ST_ERASE: begin
                a_row = er_reg;
                a_col = ec_reg;
                ram_we = 1'b1;
                ram_wdata = atp_pkg::CH_SPACE;
            end
            atp_pkg::ST_READ: begin
                a_row = RW'(rrow_reg);
                a_col = CW'(rcol_reg);
            end
            default: ram_we = 1'b0;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == atp_pkg::ST_IDLE);
        m_valid = (state_reg == atp_pkg::ST_RESP);
        m_cell_char = cell_reg;
        m_cursor_row = 5'(row_reg);
        m_cursor_col = 7'(col_reg);
        m_escape_active = (mode_reg == atp_pkg::MODE_ESC) || (mode_reg == atp_pkg::MODE_SEQ);
    end

    `ATP_ASSERT_IMPL(a_excl, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `ATP_ASSERT_IMPL(a_col_rng, aclk, aresetn, 1'b1, 32'(col_reg) < SCREEN_COLS)
    `ATP_ASSERT_NEXT(a_resp_done, aclk, aresetn, m_valid && m_ready, s_ready)
endmodule

// File: hw/rtl/atp_ram.sv
// Generic single-port RAM with registered read.
module atp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: dv/tb_checker.sv
// Checker: tracks the terminal page state, predicts each result and compares it.
module tb_checker
    import atp_pkg::*;
#(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 80,
    parameter int STORE_ROWS  = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_data_byte,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_cell_char,
    input  logic [4:0] m_cursor_row,
    input  logic [6:0] m_cursor_col,
    input  logic       m_escape_active,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] chr;
        logic [4:0] row;
        logic [6:0] col;
        logic       esc;
    } screen_reply_t;

    logic [7:0] page [STORE_ROWS*SCREEN_COLS];
    int    top, crow, ccol, num1, num2;
    mode_t mode;
    form_t form;
    logic [7:0] lead;
    screen_reply_t replies_due[$];

    function automatic int cell_idx(int r, int c);
        return ((top + r) % STORE_ROWS) * SCREEN_COLS + c;
    endfunction

    function automatic void blank(int r, int c0, int c1);
        for (int c = c0; c < c1 && c < SCREEN_COLS; c++) page[cell_idx(r, c)] = CH_SPACE;
    endfunction

    function automatic void put(logic [7:0] b);
        page[cell_idx(crow, ccol)] = b;
        if (ccol < SCREEN_COLS - 1) ccol++;
    endfunction

    function automatic bit alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic int sat(int v, int d);
        return (v * 10 + d > 255) ? 255 : v * 10 + d;
    endfunction

    function automatic void end_seq(logic [7:0] l);
        int n;
        n = (form == FORM_BRACKET) ? 0 : (form == FORM_FIRST) ? num1 : 256;
        if (l == CH_H) begin
            if (form == FORM_BRACKET) begin
                crow = 0;
                ccol = 0;
            end else if (form == FORM_SECOND) begin
                crow = (num1 == 0) ? 0 : num1 - 1;
                ccol = (num2 == 0) ? 0 : num2 - 1;
                if (crow > SCREEN_ROWS - 1) crow = SCREEN_ROWS - 1;
                if (ccol > SCREEN_COLS - 1) ccol = SCREEN_COLS - 1;
            end
        end else if (l == CH_K) begin
            if (n == 0) blank(crow, ccol, SCREEN_COLS);
            else if (n == 1) blank(crow, 0, ccol + 1);
            else if (n == 2) blank(crow, 0, SCREEN_COLS);
        end else if (l == CH_J) begin
            if (n == 0) begin
                blank(crow, ccol, SCREEN_COLS);
                for (int r = crow + 1; r < SCREEN_ROWS; r++) blank(r, 0, SCREEN_COLS);
            end else if (n == 1) begin
                for (int r = 0; r < crow; r++) blank(r, 0, SCREEN_COLS);
                blank(crow, 0, ccol + 1);
            end else if (n == 2) begin
                for (int r = 0; r < SCREEN_ROWS; r++) blank(r, 0, SCREEN_COLS);
            end
        end else if (l == CH_M && form == FORM_DIRECT) begin
            top = (top + STORE_ROWS - 1) % STORE_ROWS;
        end
        mode = MODE_GROUND;
        form = FORM_NONE;
    endfunction

    function automatic void text_byte(logic [7:0] b);
        if (b == CH_ESC) begin
            mode = MODE_ESC;
            num1 = 0;
            num2 = 0;
            form = FORM_NONE;
        end else if (b == CH_CR) begin
            ccol = 0;
        end else if (b == CH_LF) begin
            if (crow >= SCREEN_ROWS - 1) top = (top + 1) % STORE_ROWS;
            else crow++;
        end else if (b == CH_BS) begin
            if (ccol > 0) ccol--;
        end else if (b == CH_BEL || b == CH_VT || b == CH_FF) begin
        end else if (b >= LEAD_LO && b <= LEAD_HI) begin
            lead = b;
            mode = MODE_LEAD;
        end else begin
            put(b);
        end
    endfunction

    function automatic void seq_byte(logic [7:0] b);
        if (alpha(b)) begin
            end_seq(b);
        end else if (b >= "0" && b <= "9") begin
            case (form)
                FORM_BRACKET: begin num1 = b - CH_0; form = FORM_FIRST; end
                FORM_FIRST:   num1 = sat(num1, b - CH_0);
                FORM_SEMI:    begin num2 = b - CH_0; form = FORM_SECOND; end
                FORM_SECOND:  num2 = sat(num2, b - CH_0);
                default:      form = FORM_OTHER;
            endcase
        end else if (b == CH_SEMI && form == FORM_FIRST) begin
            form = FORM_SEMI;
        end else begin
            form = FORM_OTHER;
        end
    endfunction

    function automatic screen_reply_t apply_item(logic f, logic [7:0] b, int rr, int rc);
        screen_reply_t r;
        r.chr = 8'd0;
        if (!f) begin
            case (mode)
                MODE_LEAD: begin
                    mode = MODE_GROUND;
                    put(lead);
                    if ((b >= TR1_LO && b <= TR1_HI) || (b >= TR2_LO && b <= LEAD_HI)) put(b);
                    else text_byte(b);
                end
                MODE_ESC: begin
                    if (b == CH_8 || b == CH_9) mode = MODE_GROUND;
                    else if (alpha(b)) begin
                        form = FORM_DIRECT;
                        end_seq(b);
                    end else begin
                        form = (b == CH_LBR) ? FORM_BRACKET : FORM_OTHER;
                        mode = MODE_SEQ;
                    end
                end
                MODE_SEQ: seq_byte(b);
                default:  text_byte(b);
            endcase
        end else if (rr < SCREEN_ROWS && rc < SCREEN_COLS) begin
            r.chr = page[cell_idx(rr, rc)];
        end
        r.row = crow[4:0];
        r.col = ccol[6:0];
        r.esc = (mode == MODE_ESC || mode == MODE_SEQ);
        return r;
    endfunction

    assign pending = replies_due.size();

    always @(posedge aclk) begin
        screen_reply_t e;
        if (!aresetn) begin
            foreach (page[i]) page[i] = CH_SPACE;
            top = STORE_ROWS / 2;
            crow = 0;
            ccol = 0;
            mode = MODE_GROUND;
            form = FORM_NONE;
            lead = 0;
            num1 = 0;
            num2 = 0;
            fail_count = 0;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected item: cell %0h row %0d col %0d",
                           m_cell_char, m_cursor_row, m_cursor_col);
                    fail_count++;
                end else begin
                    e = replies_due.pop_front();
                    if (m_cell_char !== e.chr) begin
                        $error("cell_char exp %0h got %0h", e.chr, m_cell_char);
                        fail_count++;
                    end
                    if (m_cursor_row !== e.row) begin
                        $error("cursor_row exp %0d got %0d", e.row, m_cursor_row);
                        fail_count++;
                    end
                    if (m_cursor_col !== e.col) begin
                        $error("cursor_col exp %0d got %0d", e.col, m_cursor_col);
                        fail_count++;
                    end
                    if (m_escape_active !== e.esc) begin
                        $error("escape_active exp %0b got %0b", e.esc, m_escape_active);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                replies_due.push_back(apply_item(s_func, s_data_byte, s_read_row, s_read_col));
        end
    end
endmodule

// File: dv/tb_top.sv
// Testbench top: drives terminal bytes and cell reads, gives the verdict.
module tb_top;
    import atp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0, s_ready, s_func = 0;
    logic [7:0] s_data_byte = 0;
    logic [4:0] s_read_row = 0;
    logic [6:0] s_read_col = 0;
    logic       m_valid, m_ready = 0;
    logic [7:0] m_cell_char;
    logic [4:0] m_cursor_row;
    logic [6:0] m_cursor_col;
    logic       m_escape_active;
    int         fail_count, pending;
    bit         calm = 0, hold_sink = 0;

    always #10 aclk = ~aclk;

    ansi_terminal_page_parser i_dut (.*);
    tb_checker i_chk (.*);

    task automatic send(logic f, logic [7:0] b, logic [4:0] rr, logic [6:0] rc);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= f;
        s_data_byte <= b;
        s_read_row <= rr;
        s_read_col <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic feed(logic [7:0] b);
        send(1'b0, b, 5'($urandom), 7'($urandom));
    endtask

    task automatic feed_str(string s);
        foreach (s[i]) feed(s[i]);
    endtask

    task automatic peek();
        send(1'b1, 8'($urandom), 5'($urandom_range(0, 25)), 7'($urandom_range(0, 82)));
    endtask

    task automatic random_escape();
        string digs;
        int k;
        k = $urandom_range(0, 9);
        feed(CH_ESC);
        case (k)
            0: feed("M");
            1: feed($urandom_range(0, 1) ? CH_8 : CH_9);
            2: feed_str("[H");
            3: begin
                feed("[");
                feed_str($sformatf("%0d;%0dH", $urandom_range(0, 30),
                                   $urandom_range(0, 90)));
            end
            4: feed_str($sformatf("[%0dK", $urandom_range(0, 3)));
            5: feed_str("[K");
            6: feed_str($sformatf("[%0dJ", $urandom_range(0, 2)));
            7: feed_str("[0003;400H");
            8: feed_str("[1m");
            default: begin
                repeat ($urandom_range(1, 3)) feed(8'($urandom));
                feed("Z");
            end
        endcase
    endtask

    always @(posedge aclk) begin
        int gap;
        if (!aresetn || hold_sink) begin
            m_ready <= 0;
        end else if (gap > 0) begin
            gap--;
            m_ready <= 0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(0, 9);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        feed_str("Hi");
        send(1, 0, 0, 0);
        send(1, 0, 0, 1);
        send(1, 0, 23, 79);
        send(1, 0, 31, 127);
        feed(8'hA4); feed(8'h40);
        feed(8'h81); feed(8'hFE);
        feed(8'hB0); feed(8'h0D);
        feed(8'hFF); feed(8'h00);
        feed(CH_BS); feed(CH_BEL); feed(CH_VT); feed(CH_FF);
        feed(CH_CR); feed(CH_BS);
        feed_str("\033[24;80H");
        feed(CH_LF);
        feed_str("\033[1J\033[2K\033M\0338\0339\033[999;999H");
        repeat (85) feed("x");
        send(1, 0, 23, 79);
        feed_str("\033[2J\033[H");
        // long receiver hold-off while the sender keeps going
        fork
            begin
                hold_sink = 1;
                repeat (200) @(posedge aclk);
                hold_sink = 0;
            end
            repeat (8) feed("q");
        join
        for (int n = 0; n < 290; n++) begin
            if (n > 240) calm = 1;
            k = $urandom_range(0, 19);
            if (k < 8) feed(8'($urandom_range(8'h20, 8'h7E)));
            else if (k < 10) peek();
            else if (k < 11) begin
                feed(8'($urandom_range(LEAD_LO, LEAD_HI)));
                feed(8'($urandom));
            end else if (k < 13) feed($urandom_range(0, 1) ? CH_LF : CH_CR);
            else if (k < 15) random_escape();
            else if (k < 16) feed(8'($urandom));
            else if (k < 17) feed(CH_BS);
            else peek();
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/atp_pkg.sv
hw/rtl/atp_ram.sv
hw/rtl/ansi_terminal_page_parser.sv
dv/tb_checker.sv
dv/tb_top.sv
